### sv/spmc_pkg.sv
// Shared types, widths and register indexes of the stream pattern matcher.
`timescale 1ns / 1ps
`default_nettype none

package spmc_pkg;

    localparam int PATTERN_MAX_DEF = 16;
    localparam int BYTE_W          = 8;
    localparam int PAT_WORD_W      = 64;
    localparam int PAT_LEN_W       = 5;
    localparam int CTX_LEN_W       = 10;
    localparam int POS_W           = 32;
    localparam int CFG_INDEX_W     = 3;
    localparam int CFG_DATA_W      = 64;
    localparam int QUEUE_DEPTH     = 2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PAT_LOW     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAT_HIGH    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PAT_LENGTH  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BEFORE_LEN  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_AFTER_LEN   = 3'd4;

    // one found match, handed from the front to the back through the queue
    typedef struct packed {
        logic [POS_W-1:0]     match_start;
        logic [PAT_LEN_W-1:0] match_len;
    } spmc_hit_t;

    // context window settings used by the back
    typedef struct packed {
        logic [CTX_LEN_W-1:0] before_length;
        logic [CTX_LEN_W-1:0] after_length;
    } spmc_ctx_cfg_t;

    // queue head as seen by the back
    typedef struct packed {
        logic      valid;
        spmc_hit_t entry;
    } spmc_q_head_t;

endpackage

`default_nettype wire

### sv/spmc_stream_if.sv
// Stream interfaces for the input bytes and the match results.
`timescale 1ns / 1ps
`default_nettype none

interface spmc_in_if;
    logic                          valid;
    logic                          ready;
    logic [spmc_pkg::BYTE_W-1:0]   data_byte;
    logic                          stream_restart;

    modport source (output valid, output data_byte, output stream_restart, input ready);
    modport sink   (input valid, input data_byte, input stream_restart, output ready);
endinterface

interface spmc_out_if;
    logic                            valid;
    logic                            ready;
    logic [spmc_pkg::POS_W-1:0]      match_start;
    logic [spmc_pkg::POS_W-1:0]      context_start;
    logic [spmc_pkg::CTX_LEN_W-1:0]  before_count;
    logic [spmc_pkg::POS_W-1:0]      context_end;

    modport source (output valid, output match_start, output context_start,
                    output before_count, output context_end, input ready);
    modport sink   (input valid, input match_start, input context_start,
                    input before_count, input context_end, output ready);
endinterface

`default_nettype wire

### sv/spmc_front.sv
// Front: takes bytes, keeps history and position, compares against the pattern.
`timescale 1ns / 1ps
`default_nettype none

module spmc_front #(
    parameter int  PATTERN_MAX = spmc_pkg::PATTERN_MAX_DEF,
    localparam int LEN_W       = $clog2(PATTERN_MAX + 1)
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    spmc_in_if.sink                                 data_ch,
    input  wire logic [2*spmc_pkg::PAT_WORD_W-1:0]  pattern_bytes,
    input  wire logic [LEN_W-1:0]                   pattern_len,
    input  wire logic                               queue_full,
    output logic                                    push,
    output spmc_pkg::spmc_hit_t                     push_entry
);
    import spmc_pkg::*;

    localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

    logic [BYTE_W-1:0]      hist_reg  [PATTERN_MAX];
    logic [BYTE_W-1:0]      hist_next [PATTERN_MAX];
    logic [LEN_W-1:0]       seen_reg;
    logic [LEN_W-1:0]       seen_next;
    logic [POS_W-1:0]       pos_reg;
    logic [POS_W-1:0]       pos_next;
    logic [LEN_W-1:0]       seen_base;
    logic [POS_W-1:0]       offset;
    logic [PATTERN_MAX-1:0] byte_ok;
    logic                   accept;
    logic                   hit;

    assign data_ch.ready = !queue_full;
    assign accept        = data_ch.valid && data_ch.ready;

    // restart clears history, count and position before the byte goes in
    always_comb
    begin
        hist_next[0] = data_ch.data_byte;
        for (int i = 1; i < PATTERN_MAX; i++)
        begin
            hist_next[i] = data_ch.stream_restart ? '0 : hist_reg[i-1];
        end
        seen_base = data_ch.stream_restart ? '0 : seen_reg;
        seen_next = (seen_base < LEN_W'(PATTERN_MAX)) ? seen_base + 1'b1 : seen_base;
        offset    = data_ch.stream_restart ? '0 : pos_reg;
        pos_next  = (&offset) ? offset : offset + 1'b1;
    end

    // pattern byte k lines up with history entry len-1-k
    always_comb
    begin
        for (int k = 0; k < PATTERN_MAX; k++)
        begin
            logic [IDX_W-1:0] idx;
            idx = IDX_W'(pattern_len - LEN_W'(1) - LEN_W'(k));
            byte_ok[k] = (LEN_W'(k) >= pattern_len)
                      || (pattern_bytes[k*BYTE_W +: BYTE_W] == hist_next[idx]);
        end
        hit = (pattern_len != '0) && (seen_next >= pattern_len) && (&byte_ok);
    end

    assign push                   = accept && hit;
    assign push_entry.match_start = offset - (POS_W'(pattern_len) - POS_W'(1));
    assign push_entry.match_len   = PAT_LEN_W'(pattern_len);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PATTERN_MAX; i++)
            begin
                hist_reg[i] <= '0;
            end
            seen_reg <= '0;
            pos_reg  <= '0;
        end
        else if (accept)
        begin
            for (int i = 0; i < PATTERN_MAX; i++)
            begin
                hist_reg[i] <= hist_next[i];
            end
            seen_reg <= seen_next;
            pos_reg  <= pos_next;
        end
    end

endmodule

`default_nettype wire

### sv/spmc_queue.sv
// Short queue of found matches between front and back.
`timescale 1ns / 1ps
`default_nettype none

module spmc_queue (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire spmc_pkg::spmc_hit_t    push_entry,
    input  wire logic                   pop,
    output logic                        full,
    output spmc_pkg::spmc_q_head_t      head
);
    import spmc_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    spmc_hit_t          slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.entry = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

### sv/spmc_back.sv
// Back: turns a found match into its context window and holds the result.
`timescale 1ns / 1ps
`default_nettype none

module spmc_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire spmc_pkg::spmc_q_head_t head,
    input  wire spmc_pkg::spmc_ctx_cfg_t ctx_cfg,
    output logic                        pop,
    spmc_out_if.source                  match_ch
);
    import spmc_pkg::*;

    logic                   valid_reg;
    logic [POS_W-1:0]       start_reg;
    logic [POS_W-1:0]       ctx_start_reg;
    logic [CTX_LEN_W-1:0]   before_reg;
    logic [POS_W-1:0]       ctx_end_reg;
    logic [CTX_LEN_W-1:0]   before_next;
    logic [POS_W-1:0]       ctx_start_next;
    logic [POS_W:0]         end_sum;
    logic [POS_W-1:0]       ctx_end_next;

    assign pop = head.valid && (!valid_reg || match_ch.ready);

    always_comb
    begin
        before_next    = (POS_W'(ctx_cfg.before_length) < head.entry.match_start)
                       ? ctx_cfg.before_length : CTX_LEN_W'(head.entry.match_start);
        ctx_start_next = head.entry.match_start - POS_W'(before_next);
        end_sum        = (POS_W+1)'(head.entry.match_start)
                       + (POS_W+1)'(head.entry.match_len)
                       + (POS_W+1)'(ctx_cfg.after_length);
        ctx_end_next   = end_sum[POS_W] ? '1 : end_sum[POS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (match_ch.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            start_reg     <= head.entry.match_start;
            ctx_start_reg <= ctx_start_next;
            before_reg    <= before_next;
            ctx_end_reg   <= ctx_end_next;
        end
    end

    assign match_ch.valid         = valid_reg;
    assign match_ch.match_start   = start_reg;
    assign match_ch.context_start = ctx_start_reg;
    assign match_ch.before_count  = before_reg;
    assign match_ch.context_end   = ctx_end_reg;

endmodule

`default_nettype wire

### sv/stream_pattern_match_context_core.sv
// A byte that ends a match goes through the match queue into the output register.
// Throughput: one byte per cycle; the front compares the whole pattern in parallel and
// the back takes one queued match per cycle while the output is free. Input ready drops
// only while the two-entry match queue is full. Reset (rst_n low, asynchronous) clears history,
// position, byte count, queue and output valid, and returns the config registers to defaults.
`timescale 1ns / 1ps
`default_nettype none

module stream_pattern_match_context_core #(
    parameter int PATTERN_MAX = spmc_pkg::PATTERN_MAX_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    spmc_in_if.sink                                 data_ch,
    spmc_out_if.source                              match_ch,
    input  wire logic                               cfg_we,
    input  wire logic [spmc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [spmc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import spmc_pkg::*;

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);

    // configuration registers
    logic [PAT_WORD_W-1:0]  pat_low_reg;
    logic [PAT_WORD_W-1:0]  pat_high_reg;
    logic [PAT_LEN_W-1:0]   pat_len_reg;
    logic [CTX_LEN_W-1:0]   before_len_reg;
    logic [CTX_LEN_W-1:0]   after_len_reg;

    logic [LEN_W-1:0]       pat_len_eff;
    spmc_ctx_cfg_t          ctx_cfg;
    logic                   q_push;
    spmc_hit_t              q_push_entry;
    logic                   q_pop;
    logic                   q_full;
    spmc_q_head_t           q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg    <= '0;
            pat_high_reg   <= '0;
            pat_len_reg    <= PAT_LEN_W'(1);
            before_len_reg <= '0;
            after_len_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PAT_LOW:    pat_low_reg    <= cfg_data;
                CFG_PAT_HIGH:   pat_high_reg   <= cfg_data;
                CFG_PAT_LENGTH: pat_len_reg    <= cfg_data[PAT_LEN_W-1:0];
                CFG_BEFORE_LEN: before_len_reg <= cfg_data[CTX_LEN_W-1:0];
                CFG_AFTER_LEN:  after_len_reg  <= cfg_data[CTX_LEN_W-1:0];
                default:        ; // unused index: write dropped
            endcase
        end
    end

    // lengths beyond the history depth act as the full depth
    assign pat_len_eff = (pat_len_reg > PAT_LEN_W'(PATTERN_MAX))
                       ? LEN_W'(PATTERN_MAX) : LEN_W'(pat_len_reg);

    assign ctx_cfg.before_length = before_len_reg;
    assign ctx_cfg.after_length  = after_len_reg;

    // front: history shift, position tracking, parallel compare
    spmc_front #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .data_ch       (data_ch),
        .pattern_bytes ({pat_high_reg, pat_low_reg}),
        .pattern_len   (pat_len_eff),
        .queue_full    (q_full),
        .push          (q_push),
        .push_entry    (q_push_entry)
    );

    // decouples front from output back-pressure
    spmc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .pop        (q_pop),
        .full       (q_full),
        .head       (q_head)
    );

    // back: context window math and output register
    spmc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (q_head),
        .ctx_cfg  (ctx_cfg),
        .pop      (q_pop),
        .match_ch (match_ch)
    );

endmodule

`default_nettype wire
